>>> rtl/core/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants of the style declaration splitter
// Character codes, parser phases and the command word that the parser
// hands to the output side through the command queue.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam logic [7:0] MAX_ENTRIES_LIMIT = 8'd255;
	localparam logic [7:0] MAX_ENTRIES_RESET = 8'd32;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;
	localparam logic [7:0] CHAR_U     = 8'h75;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_COUNT  = 1'b1;

	localparam int QDEPTH  = 4;
	localparam int QAW     = $clog2(QDEPTH);
	localparam int QCW     = $clog2(QDEPTH + 1);
	localparam int TDATA_W = 80;

	typedef enum logic [3:0] {
		PH_PROP_WAIT = 4'b0001,
		PH_PROP_IN   = 4'b0010,
		PH_VAL_WAIT  = 4'b0100,
		PH_VAL_IN    = 4'b1000
	} sds_phase_t;

	// One command per input item that yields results: a record, a count, or both
	typedef struct packed {
		logic        has_rec;
		logic        has_cnt;
		logic        prop_present;
		logic [15:0] prop_offset;
		logic [15:0] prop_length;
		logic        value_present;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [7:0]  entry_index;
		logic [7:0]  total;
	} sds_cmd_t;

	// Expected character after the given number of matched "url(" characters
	function automatic logic [7:0] url_char(input logic [1:0] progress);
		logic [7:0] ch;
		unique case (progress)
			2'd1:    ch = 8'h72;
			2'd2:    ch = 8'h6C;
			2'd3:    ch = 8'h28;
			default: ch = CHAR_U;
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/core/sds_front.sv
// ----------------------------------------------------------------------------
// sds_front: character parser
// Takes one text item per cycle while the queue is not full, tracks the
// declaration being parsed and pushes a command into the queue for every
// item that closes a record or ends the text.
// ----------------------------------------------------------------------------
module sds_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	input  logic             q_full,
	output logic             q_push,
	output sds_pkg::sds_cmd_t q_cmd
);
	import sds_pkg::*;

	sds_phase_t  phase_q, st_phase, phase_d;
	logic        wcp_q, st_wcp, wcp_d;
	logic [1:0]  url_q, st_url, url_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] poff_q, st_poff, poff_d;
	logic [15:0] plen_q, st_plen, plen_d;
	logic        pseen_q, st_pseen, pseen_d;
	logic [15:0] voff_q, st_voff, voff_d;
	logic        vseen_q, st_vseen, vseen_d;
	logic        fin_q, fin_d;
	logic [7:0]  max_q;

	logic        acc;
	logic [7:0]  ch;
	logic [7:0]  limit;
	logic        below_limit;
	logic        emit;
	logic        finish;
	logic        rec_en;
	logic        is_ws;
	logic        skip;

	assign s_tready    = !q_full;
	assign acc         = s_tvalid && s_tready;
	assign ch          = s_tdata;
	assign limit       = (max_q < MAX_ENTRIES_LIMIT) ? max_q : MAX_ENTRIES_LIMIT;
	assign below_limit = count_q < limit;
	assign is_ws       = ch <= CHAR_SPACE;

	// Step the current entry by one character
	always_comb begin
		st_phase = phase_q;
		st_wcp   = wcp_q;
		st_url   = url_q;
		st_poff  = poff_q;
		st_plen  = plen_q;
		st_pseen = pseen_q;
		st_voff  = voff_q;
		st_vseen = vseen_q;
		pos_d    = pos_q;
		emit     = 1'b0;
		finish   = 1'b0;
		skip     = 1'b0;
		if (acc && !fin_q) begin
			if (s_tlast || ch == 8'd0) begin
				finish = 1'b1;
			end else begin
				if (pos_q != 16'hFFFF) begin
					pos_d = pos_q + 16'd1;
				end
				if (below_limit) begin
					if (phase_q == PH_VAL_IN && url_q != 2'd0) begin
						if (ch == url_char(url_q)) begin
							if (url_q == 2'd3) begin
								st_wcp = 1'b1;
								st_url = 2'd0;
							end else begin
								st_url = url_q + 2'd1;
							end
						end else begin
							st_url = 2'd0;
						end
					end
					skip = is_ws && (phase_q == PH_PROP_WAIT || phase_q == PH_VAL_WAIT);
					if (is_ws || ch == CHAR_COLON) begin
						if (phase_q == PH_PROP_IN) begin
							st_plen  = pos_q - poff_q;
							st_phase = PH_VAL_WAIT;
						end
					end else if (st_wcp && ch == CHAR_CLOSE) begin
						st_wcp = 1'b0;
					end else if (!st_wcp && ch == CHAR_SEMI) begin
						st_phase = PH_PROP_WAIT;
					end else begin
						unique case (phase_q)
							PH_PROP_WAIT: begin
								st_poff  = pos_q;
								st_pseen = 1'b1;
								st_phase = PH_PROP_IN;
							end
							PH_VAL_WAIT: begin
								st_voff  = pos_q;
								st_vseen = 1'b1;
								st_url   = (ch == CHAR_U) ? 2'd1 : 2'd0;
								st_phase = PH_VAL_IN;
							end
							default: ;
						endcase
					end
					emit = !skip && st_phase == PH_PROP_WAIT;
				end
			end
		end
	end

	assign rec_en = emit || (finish && phase_q == PH_VAL_IN && below_limit);

	always_comb begin
		q_cmd.has_rec       = rec_en;
		q_cmd.has_cnt       = finish;
		q_cmd.prop_present  = st_pseen;
		q_cmd.prop_offset   = st_poff;
		q_cmd.prop_length   = st_plen;
		q_cmd.value_present = st_vseen;
		q_cmd.value_offset  = st_voff;
		q_cmd.value_length  = st_vseen ? (pos_q - st_voff) : 16'd0;
		q_cmd.entry_index   = count_q;
		q_cmd.total         = count_q + {7'd0, rec_en};
	end
	assign q_push = rec_en || finish;

	// Close the entry, end or restart the text
	always_comb begin
		phase_d = st_phase;
		wcp_d   = st_wcp;
		url_d   = st_url;
		poff_d  = st_poff;
		plen_d  = st_plen;
		pseen_d = st_pseen;
		voff_d  = st_voff;
		vseen_d = st_vseen;
		count_d = count_q;
		fin_d   = fin_q;
		if (rec_en) begin
			count_d = count_q + 8'd1;
			wcp_d   = 1'b0;
			url_d   = 2'd0;
			poff_d  = 16'd0;
			plen_d  = 16'd0;
			pseen_d = 1'b0;
			voff_d  = 16'd0;
			vseen_d = 1'b0;
		end
		if (finish) begin
			phase_d = PH_PROP_WAIT;
			fin_d   = 1'b1;
		end
		if (acc && s_tlast) begin
			phase_d = PH_PROP_WAIT;
			count_d = 8'd0;
			fin_d   = 1'b0;
			wcp_d   = 1'b0;
			url_d   = 2'd0;
			poff_d  = 16'd0;
			plen_d  = 16'd0;
			pseen_d = 1'b0;
			voff_d  = 16'd0;
			vseen_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PROP_WAIT;
			wcp_q   <= 1'b0;
			url_q   <= 2'd0;
			pos_q   <= 16'd0;
			count_q <= 8'd0;
			poff_q  <= 16'd0;
			plen_q  <= 16'd0;
			pseen_q <= 1'b0;
			voff_q  <= 16'd0;
			vseen_q <= 1'b0;
			fin_q   <= 1'b0;
			max_q   <= MAX_ENTRIES_RESET;
		end else begin
			phase_q <= phase_d;
			wcp_q   <= wcp_d;
			url_q   <= url_d;
			pos_q   <= (acc && s_tlast) ? 16'd0 : pos_d;
			count_q <= count_d;
			poff_q  <= poff_d;
			plen_q  <= plen_d;
			pseen_q <= pseen_d;
			voff_q  <= voff_d;
			vseen_q <= vseen_d;
			fin_q   <= fin_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

endmodule

>>> rtl/core/sds_queue.sv
// ----------------------------------------------------------------------------
// sds_queue: command queue
// Small register FIFO between parser and output side; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module sds_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sds_pkg::sds_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output sds_pkg::sds_cmd_t head_cmd
);
	import sds_pkg::*;

	sds_cmd_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full       = cnt_q == QCW'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

>>> rtl/core/sds_back.sv
// ----------------------------------------------------------------------------
// sds_back: result formatter
// Expands each queued command into one or two result items and holds them
// in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module sds_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  sds_pkg::sds_cmd_t           head_cmd,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [sds_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import sds_pkg::*;

	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;
	logic               m_tlast_q;
	logic               sub_q;
	logic               load;
	logic               send_rec;

	assign load     = head_valid && (!m_tvalid_q || m_tready);
	assign send_rec = head_cmd.has_rec && !sub_q;
	// Keep a command that still owes its count item
	assign pop      = load && !(send_rec && head_cmd.has_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sub_q      <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			sub_q      <= send_rec && head_cmd.has_cnt;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_rec) begin
				m_tdata_q <= {6'd0, head_cmd.entry_index, head_cmd.value_length,
					head_cmd.value_offset, head_cmd.value_present, head_cmd.prop_length,
					head_cmd.prop_offset, head_cmd.prop_present};
				m_tuser_q <= KIND_RECORD;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= {6'd0, head_cmd.total, 66'd0};
				m_tuser_q <= KIND_COUNT;
				m_tlast_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> rtl/core/style_declaration_splitter.sv
// ----------------------------------------------------------------------------
// style_declaration_splitter: inline style declaration splitter
// Splits a style text, one byte per item, into property/value records.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one text byte per item in s_tdata; s_tlast high marks
//   the end of the text (that item carries no byte). A zero byte also ends
//   the text; bytes after it are dropped until s_tlast.
//   Output stream m_*: records (m_tuser = 0) and, at the end of each text,
//   one count item (m_tuser = 1, m_tlast = 1, count in the index field).
//   cfg_we/cfg_wdata write max_entries (reset 32); write only while idle.
//   Throughput: one input item per cycle while the queue is not full. The
//   result of an accepted byte is written into the command queue and then
//   loaded into the output register, which drives m_tvalid.
//   An end of text that closes a record gives two result items; the output
//   register sends the record item first, then the count item.
//   When the receiver stalls, the output register holds its item and the
//   4-entry command queue fills; s_tready drops only when the queue is full.
//   Reset clears the parser, queue and output register; nothing is pending.
// ----------------------------------------------------------------------------
module style_declaration_splitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [7:0]                  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] text_byte
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] prop_present, [16:1] prop_offset, [32:17] prop_length,
	// [33] value_present, [49:34] value_offset, [65:50] value_length,
	// [73:66] entry_index, [79:74] zero
	output logic [sds_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,   // [0] item_kind
	output logic                        m_tlast
);
	import sds_pkg::*;

	logic     q_full;
	logic     q_push;
	sds_cmd_t q_cmd;
	logic     q_pop;
	logic     q_head_valid;
	sds_cmd_t q_head;

	sds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	sds_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head)
	);

	sds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_cmd   (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// The parser never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// Only the count item closes a text
	a_last_is_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("last flag does not match item kind");

	// Every command in the queue carries at least one result
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_head_valid |-> (q_head.has_rec || q_head.has_cnt))
		else $error("empty command at queue head");

	// No output item carries padding bits
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[79:74] == 6'd0))
		else $error("padding bits set on output");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for style_declaration_splitter
// Feeds style texts one byte per item through the input stream and predicts
// every declaration record and final count. Predictions are matched in order
// against the output stream. Directed texts come first, then random
// well-formed and noisy texts under several max_entries settings. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	import sds_pkg::*;

	localparam logic [31:0] URL_PREFIX   = "url(";
	localparam logic [7:0]  TEXT_END     = 8'h00;
	localparam logic [7:0]  CHAR_DASH    = 8'h2D;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          STUCK_LIMIT   = 1000;
	localparam int          PHASES        = 7;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic        kind;
		logic        prop_present;
		logic [15:0] prop_offset;
		logic [15:0] prop_length;
		logic        value_present;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [7:0]  entry_index;
		logic        last;
	} decl_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [7:0]         cfg_wdata = 8'h00;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	text_item_t   text_feed[$];
	decl_result_t expected_results[$];
	text_item_t   on_wire;
	decl_result_t seen_result;
	decl_result_t want_result;
	int           errors = 0;
	int           send_hold = 0;
	int           recv_hold = 0;
	bit           send_calm = 1'b0;
	bit           recv_calm = 1'b0;
	int           stuck_cycles = 0;

	// Predicted parser state
	logic [7:0]  limit_reg = MAX_ENTRIES_RESET;
	sds_phase_t  split_phase = PH_PROP_WAIT;
	logic        close_paren_wait = 1'b0;
	logic [2:0]  url_matched = 3'd0;
	logic [15:0] byte_pos = 16'd0;
	logic [7:0]  decl_count = 8'd0;
	logic [15:0] prop_start = 16'd0;
	logic [15:0] prop_len = 16'd0;
	logic        prop_seen = 1'b0;
	logic [15:0] val_start = 16'd0;
	logic        val_seen = 1'b0;
	logic        text_done = 1'b0;

	style_declaration_splitter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	task automatic clear_decl();
		prop_start = 16'd0;
		prop_len = 16'd0;
		prop_seen = 1'b0;
		val_start = 16'd0;
		val_seen = 1'b0;
		url_matched = 3'd0;
		close_paren_wait = 1'b0;
	endtask

	task automatic push_record(input logic [15:0] end_at);
		decl_result_t r;
		r = '0;
		r.kind = KIND_RECORD;
		r.prop_present = prop_seen;
		r.prop_offset = prop_start;
		r.prop_length = prop_len;
		r.value_present = val_seen;
		r.value_offset = val_start;
		if (val_seen && end_at >= val_start)
			r.value_length = end_at - val_start;
		r.entry_index = decl_count;
		expected_results.push_back(r);
		decl_count++;
		clear_decl();
	endtask

	// Flush a value in progress, then report the count
	task automatic close_text();
		decl_result_t r;
		if (split_phase == PH_VAL_IN && decl_count < limit_reg)
			push_record(byte_pos);
		r = '0;
		r.kind = KIND_COUNT;
		r.entry_index = decl_count;
		r.last = 1'b1;
		expected_results.push_back(r);
		split_phase = PH_PROP_WAIT;
	endtask

	task automatic split_step(input logic [7:0] ch, input logic eot);
		logic [15:0] at;
		logic [31:0] shifted;
		logic        skip;
		skip = 1'b0;
		if (eot) begin
			if (!text_done)
				close_text();
			split_phase = PH_PROP_WAIT;
			byte_pos = 16'd0;
			decl_count = 8'd0;
			text_done = 1'b0;
			clear_decl();
		end else if (!text_done) begin
			if (ch == TEXT_END) begin
				close_text();
				text_done = 1'b1;
			end else begin
				at = byte_pos;
				if (byte_pos != 16'hFFFF)
					byte_pos++;
				if (decl_count < limit_reg) begin
					if (split_phase == PH_VAL_IN && url_matched >= 3'd1 && url_matched <= 3'd3) begin
						shifted = URL_PREFIX << (8 * url_matched);
						if (ch == shifted[31:24]) begin
							url_matched++;
							if (url_matched == 3'd4) begin
								close_paren_wait = 1'b1;
								url_matched = 3'd0;
							end
						end else begin
							url_matched = 3'd0;
						end
					end
					if (ch <= CHAR_SPACE) begin
						if (split_phase == PH_PROP_WAIT || split_phase == PH_VAL_WAIT) begin
							skip = 1'b1;
						end else if (split_phase == PH_PROP_IN) begin
							prop_len = at - prop_start;
							split_phase = PH_VAL_WAIT;
						end
					end else if (ch == CHAR_COLON) begin
						if (split_phase == PH_PROP_IN) begin
							prop_len = at - prop_start;
							split_phase = PH_VAL_WAIT;
						end
					end else if (close_paren_wait && ch == CHAR_CLOSE) begin
						close_paren_wait = 1'b0;
					end else if (!close_paren_wait && ch == CHAR_SEMI) begin
						split_phase = PH_PROP_WAIT;
					end else if (split_phase == PH_PROP_WAIT) begin
						prop_start = at;
						prop_seen = 1'b1;
						split_phase = PH_PROP_IN;
					end else if (split_phase == PH_VAL_WAIT) begin
						val_start = at;
						val_seen = 1'b1;
						url_matched = (ch == CHAR_U) ? 3'd1 : 3'd0;
						split_phase = PH_VAL_IN;
					end
					if (!skip && split_phase == PH_PROP_WAIT)
						push_record(at);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] pick_from(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] name_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) < 8)
			c = 8'($urandom_range(8'h61, 8'h7A));
		else
			c = 8'($urandom_range(8'h21, 8'hFF));
		if (c == CHAR_COLON || c == CHAR_SEMI)
			c = CHAR_DASH;
		return c;
	endfunction

	function automatic logic [7:0] value_char(input bit allow_semi);
		logic [7:0] c;
		if ($urandom_range(0, 9) < 4)
			c = pick_from("url( )u:");
		else
			c = 8'($urandom_range(8'h21, 8'hFF));
		if (!allow_semi && c == CHAR_SEMI)
			c = CHAR_U;
		return c;
	endfunction

	function automatic logic [7:0] noise_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 6)
			return pick_from(":;()u \t");
		if (r == 6)
			return TEXT_END;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_feed.push_back('{ch: b, eot: 1'b0});
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// The byte beside an end-of-text mark is ignored; randomize it anyway
	task automatic add_end();
		text_feed.push_back('{ch: 8'($urandom_range(0, 255)), eot: 1'b1});
	endtask

	task automatic add_blank();
		repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(1, 8'h20)));
	endtask

	task automatic gen_text();
		int n_decl;
		if ($urandom_range(0, 99) < 75) begin
			n_decl = $urandom_range(0, 5);
			for (int d = 0; d < n_decl; d++) begin
				add_blank();
				repeat ($urandom_range(1, 8)) add_byte(name_char());
				add_blank();
				add_byte(CHAR_COLON);
				add_blank();
				if ($urandom_range(0, 3) == 0) begin
					add_str("url(");
					repeat ($urandom_range(0, 6)) add_byte(value_char(1'b1));
					add_byte(CHAR_CLOSE);
					repeat ($urandom_range(0, 2)) add_byte(value_char(1'b0));
				end else begin
					repeat ($urandom_range(1, 10)) add_byte(value_char(1'b0));
				end
				if (d != n_decl - 1 || $urandom_range(0, 2) != 0)
					add_byte(CHAR_SEMI);
			end
		end else begin
			repeat ($urandom_range(1, 20)) add_byte(noise_char());
		end
		if ($urandom_range(0, 4) == 0) begin
			add_byte(TEXT_END);
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
		end
		add_end();
	endtask

	task automatic wait_drained();
		while (text_feed.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				split_step(on_wire.ch, on_wire.eot);
			if (!s_tvalid || s_tready) begin
				if (send_hold != 0) begin
					send_hold--;
					s_tvalid <= 1'b0;
				end else if (text_feed.size() != 0) begin
					on_wire = text_feed.pop_front();
					s_tdata <= on_wire.ch;
					s_tlast <= on_wire.eot;
					s_tvalid <= 1'b1;
					send_hold = send_calm ? 0 : pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if ($urandom_range(0, 299) == 0)
				send_calm = !send_calm;
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_result.kind = m_tuser;
				seen_result.prop_present = m_tdata[0];
				seen_result.prop_offset = m_tdata[16:1];
				seen_result.prop_length = m_tdata[32:17];
				seen_result.value_present = m_tdata[33];
				seen_result.value_offset = m_tdata[49:34];
				seen_result.value_length = m_tdata[65:50];
				seen_result.entry_index = m_tdata[73:66];
				seen_result.last = m_tlast;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected item, expected none, got %h", $time, seen_result);
					errors++;
				end else begin
					want_result = expected_results.pop_front();
					check_field("item_kind", 16'(want_result.kind),
						16'(seen_result.kind));
					check_field("prop_present", 16'(want_result.prop_present),
						16'(seen_result.prop_present));
					check_field("prop_offset", want_result.prop_offset,
						seen_result.prop_offset);
					check_field("prop_length", want_result.prop_length,
						seen_result.prop_length);
					check_field("value_present", 16'(want_result.value_present),
						16'(seen_result.value_present));
					check_field("value_offset", want_result.value_offset,
						seen_result.value_offset);
					check_field("value_length", want_result.value_length,
						seen_result.value_length);
					check_field("entry_index", 16'(want_result.entry_index),
						16'(seen_result.entry_index));
					check_field("last", 16'(want_result.last), 16'(seen_result.last));
				end
			end
			if (recv_hold != 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!recv_calm && $urandom_range(0, 3) == 0)
					recv_hold = pick_gap();
			end
			if ($urandom_range(0, 299) == 0)
				recv_calm = !recv_calm;
		end
	end

	// Abort when neither stream moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [7:0] limit_plan [PHASES];
		int         budget_plan [PHASES];
		int         goal;
		limit_plan = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd4, 8'd0, 8'd0};
		limit_plan[5] = 8'($urandom_range(1, 255));
		limit_plan[6] = 8'($urandom_range(3, 12));
		budget_plan = '{20, 40, 50, 60, 60, 60, 60};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty text, stray separators, cut property, dangling value wait
		add_end();
		add_str(":;a;!");
		add_byte(CHAR_SPACE);
		add_end();
		// Semicolon kept inside url(...), case-sensitive prefix, zero terminator
		add_str("x:url(;);");
		add_byte(8'hFF);
		add_str(":uRL(");
		add_byte(TEXT_END);
		add_str("z");
		add_end();
		wait_drained();

		for (int k = 0; k < PHASES; k++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= limit_plan[k];
			@(posedge clk);
			cfg_we <= 1'b0;
			limit_reg = limit_plan[k];
			goal = text_feed.size() + budget_plan[k];
			while (text_feed.size() < goal)
				gen_text();
			wait_drained();
		end

		wait_drained();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
